/* rtl/esamp_pkg.sv */
// Shared types and constants for the edge uniform sampler.
`default_nettype none
package esamp_pkg;

    // Widths of the internal datapath.
    localparam int MAG_W  = 33;
    localparam int SUM_W  = 66;
    localparam int ROOT_W = 33;
    localparam int REM_W  = 35;
    localparam int Q_W    = 7;
    localparam int ACC_W  = 40;
    localparam int IDX_W  = 6;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // One input item: the two endpoints of an edge.
    typedef struct packed {
        logic signed [31:0] from_x;
        logic signed [31:0] from_y;
        logic signed [31:0] from_z;
        logic signed [31:0] to_x;
        logic signed [31:0] to_y;
        logic signed [31:0] to_z;
    } seg_t;

    // One result item: a sample point on the edge.
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [IDX_W-1:0]   sample_index;
        logic               last;
        logic               clipped;
    } sample_t;

    // Classified edge handed from the front part to the back part.
    typedef struct packed {
        logic signed [31:0] from_x;
        logic signed [31:0] from_y;
        logic signed [31:0] from_z;
        logic [2:0]         neg;
        logic [MAG_W-1:0]   mag_x;
        logic [MAG_W-1:0]   mag_y;
        logic [MAG_W-1:0]   mag_z;
        logic [IDX_W-1:0]   n;
        logic               clip;
    } job_t;

endpackage
`default_nettype wire

/* rtl/edge_uniform_sampler.sv */
// Top level of the edge uniform sampler.
//
// Usage: drive an edge on seg and raise start; the edge is taken at a clock
// edge where start is high and busy is low. The block then emits n+1 sample
// items on sample, each marked by sample_valid for exactly one cycle, with
// n = floor(length / spacing) limited to MAX_SAMPLES-1 (clipped set then).
// The receiver cannot stall; every item is taken in the cycle it is shown.
// The spacing register is written through cfg_valid/cfg_ready/cfg_data;
// the user must write it only while the block is idle, and the block
// itself does not enforce this. cfg_ready is always high.
// The front part squares the three differences, takes the square root
// two radicand bits at a time, divides by the spacing bit by bit for the
// count and hands the edge over to the queue before it takes a new edge.
// The back part takes the edge, divides each offset by n (skipped when n
// is zero) and then emits one point per cycle. A two-entry queue lets the
// front take the next edge while the back part still emits. The front
// stalls only while the queue is full.
// Reset clears all control state and sets spacing to 1.0.
`default_nettype none
module edge_uniform_sampler #(
    parameter int unsigned MAX_SAMPLES = 64,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire esamp_pkg::seg_t     seg,
    output esamp_pkg::sample_t       sample,
    output logic                     sample_valid,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [31:0]         cfg_data
);

    logic [31:0]      spacing_reg;
    esamp_pkg::job_t  front_job, back_job;
    logic             push_valid;
    logic             q_ready, q_valid, back_ready;

    assign cfg_ready = 1'b1;

    // Spacing register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= 32'(64'd1 << FRAC_BITS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            spacing_reg <= cfg_data;
        end
    end

    // Length and count.
    esamp_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .seg        (seg),
        .spacing    (spacing_reg),
        .job        (front_job),
        .push_valid (push_valid),
        .push_ready (q_ready)
    );

    // Queue between the two parts.
    esamp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_job   (front_job),
        .wr_valid (push_valid),
        .wr_ready (q_ready),
        .rd_job   (back_job),
        .rd_valid (q_valid),
        .rd_ready (back_ready)
    );

    // Point generation.
    esamp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (back_job),
        .job_valid    (q_valid),
        .job_ready    (back_ready),
        .sample       (sample),
        .sample_valid (sample_valid)
    );

endmodule
`default_nettype wire

/* rtl/esamp_front.sv */
// Front part: takes an edge, finds its length and the sample count.
`default_nettype none
module esamp_front #(
    parameter int unsigned MAX_SAMPLES = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire esamp_pkg::seg_t  seg,
    input  wire logic [31:0]      spacing,
    output esamp_pkg::job_t       job,
    output logic                  push_valid,
    input  wire logic             push_ready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_CNT  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    localparam logic [esamp_pkg::Q_W-1:0]   MAX_Q = esamp_pkg::Q_W'(MAX_SAMPLES);
    localparam logic [esamp_pkg::IDX_W-1:0] N_MAX = esamp_pkg::IDX_W'(MAX_SAMPLES - 1);

    logic [2:0]                     state_reg, state_next;
    logic [5:0]                     cnt_reg, cnt_next;
    logic signed [31:0]             from_reg [3];
    logic [2:0]                     neg_reg;
    logic [esamp_pkg::MAG_W-1:0]    mag_reg [3];
    logic [esamp_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [esamp_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [esamp_pkg::ROOT_W-1:0]   root_reg, root_next;
    logic [esamp_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [esamp_pkg::Q_W-1:0]      q_reg, q_next;

    logic                           accept;
    logic [32:0]                    diff [3];
    logic [esamp_pkg::MAG_W-1:0]    mag_sel;
    logic [esamp_pkg::SUM_W-1:0]    prod;
    logic [esamp_pkg::REM_W+1:0]    rem_sh, root_test;
    logic [esamp_pkg::ACC_W-1:0]    trial;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Coordinate differences, 33 bits so they never overflow.
    assign diff[0] = {seg.to_x[31], seg.to_x} - {seg.from_x[31], seg.from_x};
    assign diff[1] = {seg.to_y[31], seg.to_y} - {seg.from_y[31], seg.from_y};
    assign diff[2] = {seg.to_z[31], seg.to_z} - {seg.from_z[31], seg.from_z};

    // One square per cycle, accumulated into the squared length.
    assign mag_sel = mag_reg[cnt_reg[1:0]];
    assign prod    = esamp_pkg::SUM_W'(mag_sel) * esamp_pkg::SUM_W'(mag_sel);

    // Square root digit step: two radicand bits per cycle.
    assign rem_sh    = {rem_reg, sum_reg[esamp_pkg::SUM_W-1 -: 2]};
    assign root_test = {2'b00, root_reg, 2'b01};

    // Count step: one quotient bit of root / spacing per cycle.
    assign trial = acc_reg + (esamp_pkg::ACC_W'(spacing) << cnt_reg[2:0]);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        acc_next   = acc_reg;
        q_next     = q_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SQ;
                    cnt_next   = '0;
                    sum_next   = '0;
                end
            end
            ST_SQ:
            begin
                sum_next = sum_reg + prod;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd2)
                begin
                    state_next = ST_ROOT;
                    cnt_next   = 6'(esamp_pkg::ROOT_W - 1);
                    rem_next   = '0;
                    root_next  = '0;
                end
            end
            ST_ROOT:
            begin
                sum_next = sum_reg << 2;
                if (rem_sh >= root_test)
                begin
                    rem_next  = esamp_pkg::REM_W'(rem_sh - root_test);
                    root_next = {root_reg[esamp_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[esamp_pkg::REM_W-1:0];
                    root_next = {root_reg[esamp_pkg::ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = ST_CNT;
                    cnt_next   = 6'(esamp_pkg::Q_W - 1);
                    acc_next   = '0;
                    q_next     = '0;
                end
            end
            ST_CNT:
            begin
                if (trial <= esamp_pkg::ACC_W'(root_reg))
                begin
                    acc_next = trial;
                    q_next   = q_reg | (esamp_pkg::Q_W'(1) << cnt_reg[2:0]);
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        acc_reg  <= acc_next;
        q_reg    <= q_next;
        if (accept)
        begin
            from_reg[0] <= seg.from_x;
            from_reg[1] <= seg.from_y;
            from_reg[2] <= seg.from_z;
            for (int c = 0; c < 3; c++)
            begin
                neg_reg[c] <= diff[c][32];
                mag_reg[c] <= diff[c][32] ? (~diff[c] + 33'd1) : diff[c];
            end
        end
    end

    // Classified edge toward the queue.
    always_comb
    begin
        job.from_x = from_reg[0];
        job.from_y = from_reg[1];
        job.from_z = from_reg[2];
        job.neg    = neg_reg;
        job.mag_x  = mag_reg[0];
        job.mag_y  = mag_reg[1];
        job.mag_z  = mag_reg[2];
        job.clip   = (q_reg >= MAX_Q);
        job.n      = (q_reg >= MAX_Q) ? N_MAX : q_reg[esamp_pkg::IDX_W-1:0];
    end

    assign push_valid = (state_reg == ST_PUSH);

endmodule
`default_nettype wire

/* rtl/esamp_queue.sv */
// Short queue of classified edges between the front and back parts.
`default_nettype none
module esamp_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire esamp_pkg::job_t  wr_job,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    output esamp_pkg::job_t       rd_job,
    output logic                  rd_valid,
    input  wire logic             rd_ready
);

    esamp_pkg::job_t                 mem [esamp_pkg::QDEPTH];
    logic [esamp_pkg::QPTR_W-1:0]    wptr_reg, rptr_reg;
    logic [esamp_pkg::QPTR_W:0]      count_reg;
    logic                            do_wr, do_rd;

    assign wr_ready = (count_reg != (esamp_pkg::QPTR_W+1)'(esamp_pkg::QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_job   = mem[rptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wr_job;
        end
    end

endmodule
`default_nettype wire

/* rtl/esamp_back.sv */
// Back part: divides each offset by the count and emits the sample points.
`default_nettype none
module esamp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire esamp_pkg::job_t  job,
    input  wire logic             job_valid,
    output logic                  job_ready,
    output esamp_pkg::sample_t    sample,
    output logic                  sample_valid
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [5:0]                     cnt_reg, cnt_next;
    esamp_pkg::job_t                job_reg;
    logic [esamp_pkg::MAG_W-1:0]    dm_reg [3], dm_next [3];
    logic [esamp_pkg::MAG_W-1:0]    quo_reg [3], quo_next [3];
    logic [esamp_pkg::IDX_W-1:0]    drem_reg [3], drem_next [3];
    logic [esamp_pkg::MAG_W-1:0]    qacc_reg [3], qacc_next [3];
    logic [esamp_pkg::IDX_W-1:0]    racc_reg [3], racc_next [3];
    logic [esamp_pkg::IDX_W-1:0]    idx_reg, idx_next;
    esamp_pkg::sample_t             sample_reg, sample_next;
    logic                           valid_reg, valid_next;

    logic signed [31:0]             from_c [3];
    logic [esamp_pkg::IDX_W:0]      n7;
    logic [esamp_pkg::IDX_W:0]      r7 [3];
    logic [esamp_pkg::IDX_W:0]      rs [3];
    logic [33:0]                    off [3];
    logic [33:0]                    pt [3];

    assign from_c[0] = job_reg.from_x;
    assign from_c[1] = job_reg.from_y;
    assign from_c[2] = job_reg.from_z;
    assign n7        = {1'b0, job_reg.n};
    assign job_ready = (state_reg == ST_IDLE);

    // Per-lane division step and interpolation arithmetic.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            r7[c]  = {drem_reg[c], dm_reg[c][esamp_pkg::MAG_W-1]};
            rs[c]  = {1'b0, racc_reg[c]} + {1'b0, drem_reg[c]};
            if (job_reg.n == '0)
            begin
                off[c] = '0;
            end
            else
            begin
                off[c] = {1'b0, qacc_reg[c]} + 34'({racc_reg[c], 1'b0} >= n7);
            end
            pt[c] = job_reg.neg[c] ? ({{2{from_c[c][31]}}, from_c[c]} - off[c])
                                   : ({{2{from_c[c][31]}}, from_c[c]} + off[c]);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        dm_next     = dm_reg;
        quo_next    = quo_reg;
        drem_next   = drem_reg;
        qacc_next   = qacc_reg;
        racc_next   = racc_reg;
        valid_next  = 1'b0;
        sample_next = sample_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    dm_next[0] = job.mag_x;
                    dm_next[1] = job.mag_y;
                    dm_next[2] = job.mag_z;
                    for (int c = 0; c < 3; c++)
                    begin
                        quo_next[c]  = '0;
                        drem_next[c] = '0;
                        qacc_next[c] = '0;
                        racc_next[c] = '0;
                    end
                    idx_next   = '0;
                    cnt_next   = 6'(esamp_pkg::MAG_W - 1);
                    state_next = (job.n == '0) ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    dm_next[c] = dm_reg[c] << 1;
                    if (r7[c] >= n7)
                    begin
                        drem_next[c] = esamp_pkg::IDX_W'(r7[c] - n7);
                        quo_next[c]  = {quo_reg[c][esamp_pkg::MAG_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_next[c] = r7[c][esamp_pkg::IDX_W-1:0];
                        quo_next[c]  = {quo_reg[c][esamp_pkg::MAG_W-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                valid_next               = 1'b1;
                sample_next.point_x      = pt[0][31:0];
                sample_next.point_y      = pt[1][31:0];
                sample_next.point_z      = pt[2][31:0];
                sample_next.sample_index = idx_reg;
                sample_next.last         = (idx_reg == job_reg.n);
                sample_next.clipped      = job_reg.clip;
                for (int c = 0; c < 3; c++)
                begin
                    if (rs[c] >= n7)
                    begin
                        racc_next[c] = esamp_pkg::IDX_W'(rs[c] - n7);
                        qacc_next[c] = qacc_reg[c] + quo_reg[c] + 33'd1;
                    end
                    else
                    begin
                        racc_next[c] = rs[c][esamp_pkg::IDX_W-1:0];
                        qacc_next[c] = qacc_reg[c] + quo_reg[c];
                    end
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == job_reg.n)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
        begin
            job_reg <= job;
        end
        dm_reg     <= dm_next;
        quo_reg    <= quo_next;
        drem_reg   <= drem_next;
        qacc_reg   <= qacc_next;
        racc_reg   <= racc_next;
        sample_reg <= sample_next;
    end

    assign sample       = sample_reg;
    assign sample_valid = valid_reg;

    // The emitted index never passes the sample count.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> idx_reg <= job_reg.n)
        else $error("sample index beyond count");

    // Running remainders stay below the divisor.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && job_reg.n != '0) |->
            (racc_reg[0] < job_reg.n && racc_reg[1] < job_reg.n && racc_reg[2] < job_reg.n))
        else $error("interpolation remainder out of range");

    // The final sample of an edge ends the emission and is flagged last.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && idx_reg == job_reg.n) |=>
            (state_reg == ST_IDLE && valid_reg && sample_reg.last))
        else $error("edge emission did not end on last sample");

endmodule
`default_nettype wire
